### rtl/cot_pkg.sv
// Shared types for the collider overlap test: collider kinds and test selection.
// No dependencies; used by collider_overlap_test.
package cot_pkg;

  typedef enum logic [1:0] {
    KIND_RECT   = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_POINT  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    TEST_NONE   = 2'd0,
    TEST_RECT   = 2'd1,
    TEST_RADIUS = 2'd2,
    TEST_POINT  = 2'd3
  } test_t;

endpackage

### rtl/collider_overlap_test.sv
// Collider overlap test top level: pipeline of separating-axis, radius
// and box tests. Depends on cot_pkg.
//
// Usage: present one collider word on the input ports with start high; it is
// taken at that clock edge (busy is always low, so a word can enter every cycle).
// pair_end low stores the word as the held collider and gives no result.
// pair_end high tests the word against the held collider as it stands at that
// edge (a hold in the previous cycle is seen). The result appears on overlap,
// marked by a one-cycle done strobe from the register after the compare.
// Throughput is one word per cycle: every dot product of the four separating
// axes has its own multiplier, so no unit is shared between words.
// Pipeline: input register, products, dot sums, absolute sums, compare.
// Reset clears the held collider (a rectangle with all values zero) and
// drops every word still in flight. The receiver cannot stall: each result
// is shown for exactly one cycle.
module collider_overlap_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] half_u_x,
  input  logic signed [COORD_WIDTH-1:0] half_u_y,
  input  logic signed [COORD_WIDTH-1:0] half_v_x,
  input  logic signed [COORD_WIDTH-1:0] half_v_y,
  input  logic [14:0]                   radius,
  input  logic                          pair_end,
  output logic                          done,
  output logic                          overlap
);
  import cot_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int BW   = CW + 2;
  localparam int PW   = 2 * CW + 2;
  localparam int SW   = 2 * CW + 4;
  localparam int CMPW = (SW > 33) ? SW : 33;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // held collider
  logic [1:0]           held_kind;
  logic signed [CW-1:0] held_cx, held_cy, held_ux, held_uy, held_vx, held_vy;
  logic [14:0]          held_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_kind   <= KIND_RECT;
      held_cx     <= '0;
      held_cy     <= '0;
      held_ux     <= '0;
      held_uy     <= '0;
      held_vx     <= '0;
      held_vy     <= '0;
      held_radius <= '0;
    end else if (accept && !pair_end) begin
      held_kind   <= kind;
      held_cx     <= center_x;
      held_cy     <= center_y;
      held_ux     <= half_u_x;
      held_uy     <= half_u_y;
      held_vx     <= half_v_x;
      held_vy     <= half_v_y;
      held_radius <= radius;
    end
  end

  // stage 0: input register (held and current collider of one test)
  logic                 v0;
  logic [1:0]           lk, rk;
  logic signed [CW-1:0] lcx, lcy, rcx, rcy;
  logic signed [CW-1:0] ax_x [4];
  logic signed [CW-1:0] ax_y [4];
  logic [14:0]          lr, rr_in;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= accept && pair_end;
  end

  always_ff @(posedge clk) begin
    lk      <= held_kind;
    rk      <= kind;
    lcx     <= held_cx;
    lcy     <= held_cy;
    rcx     <= center_x;
    rcy     <= center_y;
    ax_x[0] <= held_ux;
    ax_y[0] <= held_uy;
    ax_x[1] <= held_vx;
    ax_y[1] <= held_vy;
    ax_x[2] <= half_u_x;
    ax_y[2] <= half_u_y;
    ax_x[3] <= half_v_x;
    ax_y[3] <= half_v_y;
    lr      <= held_radius;
    rr_in   <= radius;
  end

  // stage 1: differences, products, test selection, box test
  logic signed [DW-1:0] dx, dy;
  logic signed [BW-1:0] bl, br, bt, bb, px, py;
  logic                 rect_left, box_in;
  logic [15:0]          rad;
  test_t                test_next;

  assign dx = DW'(rcx) - DW'(lcx);
  assign dy = DW'(rcy) - DW'(lcy);

  always_comb begin
    rect_left = (lk == KIND_RECT);
    if (rect_left) begin
      bl = BW'(lcx) - BW'(ax_x[0]) - BW'(ax_x[1]);
      br = BW'(lcx) + BW'(ax_x[0]) + BW'(ax_x[1]);
      bt = BW'(lcy) - BW'(ax_y[0]) - BW'(ax_y[1]);
      bb = BW'(lcy) + BW'(ax_y[0]) + BW'(ax_y[1]);
      px = BW'(rcx);
      py = BW'(rcy);
    end else begin
      bl = BW'(rcx) - BW'(ax_x[2]) - BW'(ax_x[3]);
      br = BW'(rcx) + BW'(ax_x[2]) + BW'(ax_x[3]);
      bt = BW'(rcy) - BW'(ax_y[2]) - BW'(ax_y[3]);
      bb = BW'(rcy) + BW'(ax_y[2]) + BW'(ax_y[3]);
      px = BW'(lcx);
      py = BW'(lcy);
    end
    box_in = (px >= bl) && (px <= br) && (py <= bt) && (py >= bb);
  end

  always_comb begin
    test_next = TEST_NONE;
    rad       = '0;
    unique case ({lk, rk})
      {KIND_RECT, KIND_RECT}:     test_next = TEST_RECT;
      {KIND_RECT, KIND_POINT},
      {KIND_POINT, KIND_RECT}:    test_next = TEST_POINT;
      {KIND_CIRCLE, KIND_CIRCLE}: begin
        test_next = TEST_RADIUS;
        rad       = 16'(lr) + 16'(rr_in);
      end
      {KIND_CIRCLE, KIND_POINT}: begin
        test_next = TEST_RADIUS;
        rad       = 16'(lr);
      end
      {KIND_POINT, KIND_CIRCLE}: begin
        test_next = TEST_RADIUS;
        rad       = 16'(rr_in);
      end
      default: test_next = TEST_NONE;
    endcase
  end

  logic                 v1;
  test_t                test1;
  logic                 box1;
  logic signed [PW-1:0] pdx [4];
  logic signed [PW-1:0] pdy [4];
  logic signed [PW-1:0] pax [4][4];
  logic signed [PW-1:0] pay [4][4];
  logic signed [PW-1:0] ddx, ddy;
  logic [31:0]          rsq;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= v0;
  end

  always_ff @(posedge clk) begin
    test1 <= test_next;
    box1  <= box_in;
    ddx   <= PW'(dx * dx);
    ddy   <= PW'(dy * dy);
    rsq   <= 32'(rad * rad);
    for (int i = 0; i < 4; i++) begin
      pdx[i] <= PW'(ax_x[i] * dx);
      pdy[i] <= PW'(ax_y[i] * dy);
      for (int j = 0; j < 4; j++) begin
        pax[i][j] <= PW'(ax_x[i] * ax_x[j]);
        pay[i][j] <= PW'(ax_y[i] * ax_y[j]);
      end
    end
  end

  // stage 2: dot products
  logic                 v2;
  test_t                test2;
  logic                 box2;
  logic signed [PW-1:0] dotd [4];
  logic signed [PW-1:0] dota [4][4];
  logic signed [PW-1:0] dd2;
  logic [31:0]          rsq2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    test2 <= test1;
    box2  <= box1;
    dd2   <= ddx + ddy;
    rsq2  <= rsq;
    for (int i = 0; i < 4; i++) begin
      dotd[i] <= pdx[i] + pdy[i];
      for (int j = 0; j < 4; j++)
        dota[i][j] <= pax[i][j] + pay[i][j];
    end
  end

  // stage 3: projected distance and projected extent per axis
  function automatic logic signed [SW-1:0] abs_w(input logic signed [PW-1:0] a);
    logic signed [SW-1:0] e;
    e = SW'(a);
    return (e < 0) ? -e : e;
  endfunction

  logic                 v3;
  test_t                test3;
  logic                 box3;
  logic signed [SW-1:0] proj [4];
  logic signed [SW-1:0] ext  [4];
  logic                 in_radius;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    test3     <= test2;
    box3      <= box2;
    in_radius <= !($signed(CMPW'(dd2)) > $signed(CMPW'({1'b0, rsq2})));
    for (int i = 0; i < 4; i++) begin
      proj[i] <= abs_w(dotd[i]);
      ext[i]  <= abs_w(dota[i][0]) + abs_w(dota[i][1])
               + abs_w(dota[i][2]) + abs_w(dota[i][3]);
    end
  end

  // stage 4: compare and select the result word
  logic separated, result;

  always_comb begin
    separated = 1'b0;
    for (int i = 0; i < 4; i++)
      if (proj[i] > ext[i]) separated = 1'b1;
    unique case (test3)
      TEST_RECT:   result = !separated;
      TEST_RADIUS: result = in_radius;
      TEST_POINT:  result = box3;
      default:     result = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v3;
  end

  always_ff @(posedge clk) begin
    overlap <= result;
  end

  a_done_from_test: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && pair_end, 5))
    else $error("result word without a test word");

  a_test_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && pair_end) |-> ##5 done)
    else $error("test word lost");

  a_none_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (v3 && test3 == TEST_NONE) |=> !overlap)
    else $error("overlap reported for untestable pair");

  a_hold_stored: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !pair_end) |=> (held_kind == $past(kind)))
    else $error("held collider not stored");

endmodule
